FILE: rtl/double_ended_queue_macros.svh
// double_ended_queue_macros.svh: assertion macros shared by the deque RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define DEQ_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication, disabled while reset is held
`define DEQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

FILE: rtl/deq_pkg.sv
// deq_pkg: types and constants of the double-ended queue.
// Used by deq_ctrl, deq_datapath and double_ended_queue; depends on nothing.
`default_nettype none

package deq_pkg;

    localparam int DEQ_CAPACITY = 16;
    localparam int DATA_W       = 64;
    localparam int ACTION_W     = 3;
    localparam int STATUS_W     = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_REVERSE    = 3'd4,
        ACT_CLEAR      = 3'd5,
        ACT_NONE       = 3'd6
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_READ = 2'd2,
        ST_RESP = 2'd3
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // apply the action, write the store
        logic read;   // read front and back slots
    } deq_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/deq_ctrl.sv
// deq_ctrl: sequencing state machine of the double-ended queue.
// Depends on deq_pkg and double_ended_queue_macros.svh.
`default_nettype none
`include "double_ended_queue_macros.svh"

module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    output deq_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: state_next = ST_READ;
            ST_READ: state_next = ST_RESP;
            ST_RESP: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready  = 1'b0;
        m_valid  = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_EXEC: cmd.exec = 1'b1;
            ST_READ: cmd.read = 1'b1;
            ST_RESP: m_valid  = 1'b1;
            default: ;
        endcase
    end

    // An accepted item runs through execute, read and response in turn
    `DEQ_ASSERT_NEXT(a_load_exec, aclk, aresetn, cmd.load, cmd.exec)
    `DEQ_ASSERT_NEXT(a_exec_read, aclk, aresetn, cmd.exec, cmd.read)
    `DEQ_ASSERT_NEXT(a_read_resp, aclk, aresetn, cmd.read, m_valid && !s_ready)

endmodule

`default_nettype wire

FILE: rtl/deq_datapath.sv
// deq_datapath: ring store, pointers and result registers of the deque.
// Depends on deq_pkg and double_ended_queue_macros.svh.
`default_nettype none
`include "double_ended_queue_macros.svh"

module deq_datapath
    import deq_pkg::*;
#(
    parameter int CAPACITY = DEQ_CAPACITY
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire deq_cmd_t                       cmd,
    input  wire logic [ACTION_W-1:0]            s_action,
    input  wire logic [DATA_W-1:0]              s_value,
    output logic [DATA_W-1:0]                   m_front_value,
    output logic [DATA_W-1:0]                   m_back_value,
    output logic [$clog2(CAPACITY+1)-1:0]       m_count,
    output logic                                m_empty_res,
    output logic [STATUS_W-1:0]                 m_status
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [PW:0]   CAP_P = (PW+1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // Ring add and subtract; correct for operands below CAPACITY
    function automatic logic [PW-1:0] add_mod(input logic [PW-1:0] p, input logic [PW-1:0] d);
        logic [PW:0] s;
        s = {1'b0, p} + {1'b0, d};
        if (s >= CAP_P) s = s - CAP_P;
        return s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] sub_mod(input logic [PW-1:0] p, input logic [PW-1:0] d);
        logic [PW:0] s;
        s = {1'b0, p} + CAP_P - {1'b0, d};
        if (s >= CAP_P) s = s - CAP_P;
        return s[PW-1:0];
    endfunction

    action_t            action_reg;
    logic [DATA_W-1:0]  value_reg;
    logic [CW-1:0]      count_reg,  count_next;
    logic [PW-1:0]      front_reg,  front_next;
    logic               rev_reg,    rev_next;
    status_t            status_reg, status_next;
    logic [DATA_W-1:0]  rd_front_reg;
    logic [DATA_W-1:0]  rd_back_reg;
    logic [DATA_W-1:0]  mem [CAPACITY];

    logic               full;
    logic               empty;
    logic [CW-1:0]      count_m1;
    logic [PW-1:0]      off_sel;
    logic [PW-1:0]      slot_far;
    logic [PW-1:0]      slot_fwd1;
    logic [PW-1:0]      slot_bwd1;
    logic               mem_we;
    logic [PW-1:0]      mem_waddr;

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= action_t'(s_action);
            value_reg  <= s_value;
        end
    end

    assign full     = (count_reg == CAP_C);
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - CW'(1);

    // Slot at offset count (push back) or count-1 (reverse, back read)
    assign off_sel   = (cmd.exec && action_reg == ACT_PUSH_BACK) ? count_reg[PW-1:0]
                                                                 : count_m1[PW-1:0];
    assign slot_far  = rev_reg ? sub_mod(front_reg, off_sel) : add_mod(front_reg, off_sel);
    // One step towards the back, and one step before the front
    assign slot_fwd1 = rev_reg ? sub_mod(front_reg, PW'(1)) : add_mod(front_reg, PW'(1));
    assign slot_bwd1 = rev_reg ? add_mod(front_reg, PW'(1)) : sub_mod(front_reg, PW'(1));

    // Action decode
    always_comb begin
        count_next  = count_reg;
        front_next  = front_reg;
        rev_next    = rev_reg;
        status_next = STAT_OK;
        mem_we      = 1'b0;
        mem_waddr   = slot_far;
        case (action_reg)
            ACT_PUSH_BACK: begin
                if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            ACT_PUSH_FRONT: begin
                if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = slot_bwd1;
                    front_next = slot_bwd1;
                    count_next = count_reg + CW'(1);
                end
            end
            ACT_POP_FRONT: begin
                if (empty) begin
                    status_next = STAT_EMPTY;
                end else begin
                    front_next = slot_fwd1;
                    count_next = count_m1;
                end
            end
            ACT_POP_BACK: begin
                if (empty) begin
                    status_next = STAT_EMPTY;
                end else begin
                    count_next = count_m1;
                end
            end
            ACT_REVERSE: begin
                if (empty) begin
                    status_next = STAT_EMPTY;
                end else begin
                    front_next = slot_far;
                    rev_next   = !rev_reg;
                end
            end
            ACT_CLEAR: begin
                count_next = '0;
                front_next = '0;
                rev_next   = 1'b0;
            end
            default: ;
        endcase
    end

    // Queue state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            front_reg  <= '0;
            rev_reg    <= 1'b0;
            status_reg <= STAT_OK;
        end else if (cmd.exec) begin
            count_reg  <= count_next;
            front_reg  <= front_next;
            rev_reg    <= rev_next;
            status_reg <= status_next;
        end
    end

    // Ring store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (cmd.exec && mem_we) begin
            mem[mem_waddr] <= value_reg;
        end
        if (cmd.read) begin
            rd_front_reg <= mem[front_reg];
            rd_back_reg  <= mem[slot_far];
        end
    end

    // Result
    assign m_front_value = empty ? '0 : rd_front_reg;
    assign m_back_value  = empty ? '0 : rd_back_reg;
    assign m_count       = count_reg;
    assign m_empty_res   = empty;
    assign m_status      = status_reg;

    `DEQ_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CAP_C)
    `DEQ_ASSERT_NEXT(a_full_hold, aclk, aresetn,
                     cmd.exec && full && (action_reg == ACT_PUSH_BACK ||
                                          action_reg == ACT_PUSH_FRONT),
                     count_reg == $past(count_reg) && status_reg == STAT_FULL)
    `DEQ_ASSERT_NEXT(a_empty_hold, aclk, aresetn,
                     cmd.exec && empty && (action_reg == ACT_POP_FRONT ||
                                           action_reg == ACT_POP_BACK ||
                                           action_reg == ACT_REVERSE),
                     count_reg == '0 && status_reg == STAT_EMPTY)

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue.sv
// double_ended_queue: top level of the bounded double-ended queue.
// Depends on deq_pkg, deq_ctrl and deq_datapath.
//
// Usage:
//   Input channel (s_valid/s_ready) takes one item: an action code in
//   s_action (push back, push front, pop front, pop back, reverse, clear,
//   none) and the 64-bit value to push in s_value.
//   Result channel (m_valid/m_ready) gives one item per input item: front
//   and back values (zero when empty), entry count, empty flag and status
//   (ok, push refused because full, pop or reverse on empty).
//   Entries sit in a ring of CAPACITY slots with a front pointer and a
//   direction flag, so reversal moves no data.
//   m_valid rises once the controller has passed from the capture of the
//   input item through its execute and store read steps.
//   A new item is taken only after the result is taken, as the controller
//   runs its capture, execute, store read and response steps in turn; the store
//   is read at front and back through its registered read ports.
//   Reset (aresetn low, synchronous) empties the queue; the store contents
//   are not cleared, and a slot not yet written never reaches the result.
//   While the receiver stalls the result is held and s_ready stays low.
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int CAPACITY = DEQ_CAPACITY
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [ACTION_W-1:0]         s_action,
    input  wire logic [DATA_W-1:0]           s_value,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [DATA_W-1:0]                m_front_value,
    output logic [DATA_W-1:0]                m_back_value,
    output logic [$clog2(CAPACITY+1)-1:0]    m_count,
    output logic                             m_empty_res,
    output logic [STATUS_W-1:0]              m_status
);

    deq_cmd_t cmd;

    deq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    deq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_action      (s_action),
        .s_value       (s_value),
        .m_front_value (m_front_value),
        .m_back_value  (m_back_value),
        .m_count       (m_count),
        .m_empty_res   (m_empty_res),
        .m_status      (m_status)
    );

endmodule

`default_nettype wire
